// File: rtl/core/upd_pkg.sv
// Shared types, character codes and helper functions for the URL percent decoder.
package upd_pkg;

	// Character codes that the decoder treats specially.
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// One escape digit carries four bits of the decoded byte.
	localparam int unsigned HEX_RADIX   = 16;
	localparam int unsigned HEX_DIGIT_W = $clog2(HEX_RADIX);

	// A single input word yields at most three output words.
	localparam int unsigned MAX_OUT = 3;
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);

	// Escape tracking: nothing pending, '%' seen, '%' and one digit seen.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// Group of decoded words produced by one input word.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} bundle_t;

	// True for 0-9, A-F and a-f.
	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) ||
		       ((c >= 8'h41) && (c <= 8'h46)) ||
		       ((c >= 8'h61) && (c <= 8'h66));
	endfunction

	// Value of a hex digit; anything else gives zero.
	function automatic logic [HEX_DIGIT_W-1:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			v = c - 8'h30;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			v = c - 8'h41 + 8'd10;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h61 + 8'd10;
		end
		return v[HEX_DIGIT_W-1:0];
	endfunction

endpackage

// File: rtl/core/upd_front.sv
// Front end: accepts input words, tracks escape state and forms output bundles.
module upd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      in_byte,
	input  logic            last_byte,
	input  logic            q_full,
	output logic            wr_en,
	output upd_pkg::bundle_t wr_data
);

	upd_pkg::phase_t phase_q, phase_d, mid_phase;
	logic [7:0]      digit_q, digit_d, mid_digit;
	logic            accept;
	logic            c_hex;
	logic            fresh_emit;
	logic [7:0]      fresh_val;
	logic [upd_pkg::CNT_W-1:0] n;
	upd_pkg::bundle_t bnd;

	assign accept = push && !q_full;
	assign c_hex  = upd_pkg::is_hex(in_byte);

	// A byte handled with no escape pending: '+' becomes a space, '%' opens an escape.
	assign fresh_emit = (in_byte != upd_pkg::CH_PERCENT);
	assign fresh_val  = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;

	// Next escape state, first after the byte itself and then after any end-of-stream flush.
	always_comb begin
		mid_phase = upd_pkg::PH_IDLE;
		mid_digit = digit_q;
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (c_hex) begin
					mid_phase = upd_pkg::PH_DIGIT;
					mid_digit = in_byte;
				end else if (in_byte == upd_pkg::CH_PERCENT) begin
					mid_phase = upd_pkg::PH_PCT;
				end
			end
			upd_pkg::PH_DIGIT: begin
				if (!c_hex && (in_byte == upd_pkg::CH_PERCENT)) begin
					mid_phase = upd_pkg::PH_PCT;
				end
			end
			default: begin
				if (in_byte == upd_pkg::CH_PERCENT) begin
					mid_phase = upd_pkg::PH_PCT;
				end
			end
		endcase
		phase_d = last_byte ? upd_pkg::PH_IDLE : mid_phase;
		digit_d = last_byte ? 8'h00 : mid_digit;
	end

	// Words produced by this input, in order, packed into one bundle.
	always_comb begin
		bnd = '0;
		n   = '0;
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (!c_hex) begin
					bnd.data[n] = upd_pkg::CH_PERCENT;
					n = n + 1'b1;
					if (fresh_emit) begin
						bnd.data[n] = fresh_val;
						n = n + 1'b1;
					end
				end
			end
			upd_pkg::PH_DIGIT: begin
				if (c_hex) begin
					bnd.data[n] = {upd_pkg::hex_value(digit_q), upd_pkg::hex_value(in_byte)};
					n = n + 1'b1;
				end else begin
					bnd.data[n] = upd_pkg::CH_PERCENT;
					n = n + 1'b1;
					bnd.data[n] = digit_q;
					n = n + 1'b1;
					if (fresh_emit) begin
						bnd.data[n] = fresh_val;
						n = n + 1'b1;
					end
				end
			end
			default: begin
				if (fresh_emit) begin
					bnd.data[n] = fresh_val;
					n = n + 1'b1;
				end
			end
		endcase
		// An escape left open at the end of the stream goes out literally.
		if (last_byte) begin
			if (mid_phase == upd_pkg::PH_PCT) begin
				bnd.data[n] = upd_pkg::CH_PERCENT;
				n = n + 1'b1;
			end else if (mid_phase == upd_pkg::PH_DIGIT) begin
				bnd.data[n] = upd_pkg::CH_PERCENT;
				n = n + 1'b1;
				bnd.data[n] = mid_digit;
				n = n + 1'b1;
			end
		end
		bnd.count = n;
		bnd.last  = last_byte;
	end

	assign wr_en   = accept && (n != '0);
	assign wr_data = bnd;

	// Escape state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			digit_q <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
		end
	end

endmodule

// File: rtl/core/upd_queue.sv
// Short bundle queue that decouples the front end from the output sequencer.
module upd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  upd_pkg::bundle_t wr_data,
	input  logic             rd_en,
	output upd_pkg::bundle_t rd_data,
	output logic             q_full,
	output logic             q_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	upd_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("write into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("read from an empty queue");
	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data.count != '0))
		else $error("empty bundle written");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("occupancy did not rise on write");
`endif

endmodule

// File: rtl/core/upd_back.sv
// Back end: walks each bundle one word at a time into the output register.
module upd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  upd_pkg::bundle_t rd_data,
	input  logic             q_empty,
	output logic             rd_en,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             out_last
);

	logic [upd_pkg::CNT_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      out_last_q;
	logic                      pop_ok;
	logic                      take;
	logic                      is_end;

	// A word moves into the output register when it is free or being emptied.
	assign pop_ok = pop && out_valid_q;
	assign take   = !q_empty && (!out_valid_q || pop_ok);
	assign is_end = (idx_q == rd_data.count - 1'b1);
	assign rd_en  = take && is_end;

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	// Word index within the head bundle and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q       <= is_end ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload; the end mark rides on the final word of the final bundle.
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= rd_data.data[idx_q];
			out_last_q <= rd_data.last && is_end;
		end
	end

endmodule

// File: rtl/core/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// Usage:
//   Input channel: present in_byte and last_byte with push; a word is taken at a
//   rising edge where push is high and full is low. Raise last_byte on the final
//   byte of a stream.
//   Output channel: while empty is low, out_byte and out_last hold the oldest
//   decoded word; it is taken at a rising edge where pop is high.
//   A '+' decodes to a space and '%' with two hex digits to the byte they spell.
//   A broken escape is passed through literally, so one input word may give none,
//   one, two or three output words; out_last marks the final one of a stream.
// Path: an accepted word's bundle is written into the queue, then its words move to the output register.
// Throughput: one input word per cycle while each yields at most one output word
//   and the receiver pops every word; the output register drains one word per cycle
//   while pop is held high, so a word that yields two or three output words holds the
//   output side longer, and the bundle queue (QUEUE_DEPTH entries) absorbs the difference before full is raised.
// Reset: arst_n clears escape state, the queue occupancy and the output valid flag at once.
// A stalled receiver holds the output word; the queue fills and full then holds
// off the sender without loss.
module url_percent_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic             wr_en, rd_en, q_full, q_empty;
	upd_pkg::bundle_t wr_data, rd_data;

	assign full = q_full;

	// Escape tracking and bundle formation.
	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	// Bundle queue between the two halves.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// Word-by-word output sequencing.
	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_data  (rd_data),
		.q_empty  (q_empty),
		.rd_en    (rd_en),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule
